// ===== rtl/core/fsce_pkg.sv =====
// package for the format spec charset expander
// holds the parse phase and character set types, the set length and character tables
// no dependencies
package fsce_pkg;

    typedef enum logic [3:0] {
        PH_LIT     = 4'd0,
        PH_FLAGS   = 4'd1,
        PH_WDIG    = 4'd2,
        PH_PRECOPT = 4'd3,
        PH_PSTART  = 4'd4,
        PH_PDIG    = 4'd5,
        PH_LENOPT  = 4'd6,
        PH_AFTER_L = 4'd7,
        PH_AFTER_H = 4'd8,
        PH_SPEC    = 4'd9
    } t_phase;

    typedef enum logic [3:0] {
        SET_NONE    = 4'd0,
        SET_LIT     = 4'd1,
        SET_SIGNED  = 4'd2,
        SET_DECIMAL = 4'd3,
        SET_HEX_LO  = 4'd4,
        SET_HEX_UP  = 4'd5,
        SET_OCTAL   = 4'd6,
        SET_BINARY  = 4'd7,
        SET_FLOAT   = 4'd8,
        SET_PERCENT = 4'd9
    } t_set;

    localparam int CharW = 8;
    localparam int IdxW  = 4;

    // one run handed from the parser to the emitter
    typedef struct packed {
        t_set             kind;
        logic [CharW-1:0] lit;
    } t_run;

    // specifier byte to its character set
    function automatic t_set spec_kind(input logic [CharW-1:0] c);
        t_set k;
        k = SET_NONE;
        case (c)
            "d", "i": k = SET_SIGNED;
            "u":      k = SET_DECIMAL;
            "x":      k = SET_HEX_LO;
            "X", "p": k = SET_HEX_UP;
            "o":      k = SET_OCTAL;
            "b":      k = SET_BINARY;
            "f", "F": k = SET_FLOAT;
            "%":      k = SET_PERCENT;
            default:  k = SET_NONE;
        endcase
        return k;
    endfunction

    // index of the final character of a set
    function automatic logic [IdxW-1:0] last_idx(input t_set k);
        logic [IdxW-1:0] n;
        n = '0;
        case (k)
            SET_SIGNED:  n = IdxW'(10);
            SET_DECIMAL: n = IdxW'(9);
            SET_HEX_LO:  n = IdxW'(15);
            SET_HEX_UP:  n = IdxW'(15);
            SET_OCTAL:   n = IdxW'(7);
            SET_BINARY:  n = IdxW'(1);
            SET_FLOAT:   n = IdxW'(11);
            default:     n = '0;
        endcase
        return n;
    endfunction

    // character at a given place of a set
    function automatic logic [CharW-1:0] set_char(input t_set k, input logic [IdxW-1:0] idx,
                                                  input logic [CharW-1:0] lit);
        logic [CharW-1:0] ch;
        logic [CharW-1:0] digit;
        digit = CharW'("0") + CharW'(idx);
        ch    = digit;
        case (k)
            SET_LIT:     ch = lit;
            SET_PERCENT: ch = CharW'("%");
            SET_SIGNED:  ch = (idx == IdxW'(10)) ? CharW'("-") : digit;
            SET_FLOAT: begin
                if (idx == IdxW'(10)) begin
                    ch = CharW'(".");
                end else if (idx == IdxW'(11)) begin
                    ch = CharW'("-");
                end else begin
                    ch = digit;
                end
            end
            SET_HEX_LO:  ch = (idx >= IdxW'(10)) ? CharW'("a") + CharW'(idx - IdxW'(10)) : digit;
            SET_HEX_UP:  ch = (idx >= IdxW'(10)) ? CharW'("A") + CharW'(idx - IdxW'(10)) : digit;
            default:     ch = digit;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/core/fsce_parser.sv =====
// conversion parser: parse phase register and per-byte decode
// depends on fsce_pkg
module fsce_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [fsce_pkg::CharW-1:0]    i_format_char,
    input  logic                          i_end_of_format,
    output fsce_pkg::t_run                o_run
);

    fsce_pkg::t_phase r_phase, n_phase;
    fsce_pkg::t_set   kind;

    logic [fsce_pkg::CharW-1:0] c;
    logic                       is_dig;
    logic                       is_flag;

    // results of each skip stage, chained as in the grammar
    fsce_pkg::t_phase len_ph, prec_ph, width_ph, flags_ph;
    fsce_pkg::t_set   len_k;

    assign c       = i_format_char;
    assign is_dig  = (c >= "0") && (c <= "9");
    assign is_flag = (c == "0") || (c == "-") || (c == "+") || (c == " ") || (c == "#");

    always_comb begin
        len_k  = fsce_pkg::SET_NONE;
        len_ph = fsce_pkg::PH_LIT;
        if (c == "l") begin
            len_ph = fsce_pkg::PH_AFTER_L;
        end else if (c == "h") begin
            len_ph = fsce_pkg::PH_AFTER_H;
        end else if (c == "j" || c == "z") begin
            len_ph = fsce_pkg::PH_SPEC;
        end else begin
            len_k = fsce_pkg::spec_kind(c);
        end
        prec_ph  = (c == ".") ? fsce_pkg::PH_PSTART : len_ph;
        width_ph = is_dig ? fsce_pkg::PH_WDIG :
                   (c == "*") ? fsce_pkg::PH_PRECOPT : prec_ph;
        flags_ph = is_flag ? fsce_pkg::PH_FLAGS : width_ph;
    end

    always_comb begin
        n_phase = r_phase;
        kind    = fsce_pkg::SET_NONE;
        case (r_phase)
            fsce_pkg::PH_LIT: begin
                if (c == "%") begin
                    n_phase = fsce_pkg::PH_FLAGS;
                end else begin
                    kind = fsce_pkg::SET_LIT;
                end
            end
            fsce_pkg::PH_FLAGS: begin
                n_phase = flags_ph;
                if (flags_ph == fsce_pkg::PH_LIT) kind = len_k;
            end
            fsce_pkg::PH_WDIG: begin
                n_phase = is_dig ? fsce_pkg::PH_WDIG : prec_ph;
                if (!is_dig && prec_ph == fsce_pkg::PH_LIT) kind = len_k;
            end
            fsce_pkg::PH_PRECOPT: begin
                n_phase = prec_ph;
                if (prec_ph == fsce_pkg::PH_LIT) kind = len_k;
            end
            fsce_pkg::PH_PSTART: begin
                if (is_dig) begin
                    n_phase = fsce_pkg::PH_PDIG;
                end else if (c == "*") begin
                    n_phase = fsce_pkg::PH_LENOPT;
                end else begin
                    n_phase = len_ph;
                    kind    = len_k;
                end
            end
            fsce_pkg::PH_PDIG: begin
                if (is_dig) begin
                    n_phase = fsce_pkg::PH_PDIG;
                end else begin
                    n_phase = len_ph;
                    kind    = len_k;
                end
            end
            fsce_pkg::PH_LENOPT: begin
                n_phase = len_ph;
                kind    = len_k;
            end
            fsce_pkg::PH_AFTER_L: begin
                if (c == "l") begin
                    n_phase = fsce_pkg::PH_SPEC;
                end else begin
                    n_phase = fsce_pkg::PH_LIT;
                    kind    = fsce_pkg::spec_kind(c);
                end
            end
            fsce_pkg::PH_AFTER_H: begin
                if (c == "h") begin
                    n_phase = fsce_pkg::PH_SPEC;
                end else begin
                    n_phase = fsce_pkg::PH_LIT;
                    kind    = fsce_pkg::spec_kind(c);
                end
            end
            fsce_pkg::PH_SPEC: begin
                n_phase = fsce_pkg::PH_LIT;
                kind    = fsce_pkg::spec_kind(c);
            end
            default: begin
                n_phase = fsce_pkg::PH_LIT;
            end
        endcase
        // zero byte ends the string silently
        if (c == '0) begin
            n_phase = fsce_pkg::PH_LIT;
            kind    = fsce_pkg::SET_NONE;
        end
        if (i_end_of_format) n_phase = fsce_pkg::PH_LIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fsce_pkg::PH_LIT;
        end else if (i_accept) begin
            r_phase <= n_phase;
        end
    end

    assign o_run.kind = kind;
    assign o_run.lit  = c;

endmodule

// ===== rtl/core/fsce_emitter.sv =====
// run emitter: holds one character set run and steps through it one item per cycle while i_out_ready is high
// depends on fsce_pkg
module fsce_emitter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  fsce_pkg::t_run                i_run,
    output logic                          o_can_load,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [fsce_pkg::CharW-1:0]    o_out_char,
    output logic                          o_last_of_run
);

    logic                       r_valid;
    fsce_pkg::t_set             r_kind;
    logic [fsce_pkg::CharW-1:0] r_lit;
    logic [fsce_pkg::IdxW-1:0]  r_idx;
    logic [fsce_pkg::IdxW-1:0]  r_last;

    logic is_last;
    logic take;
    logic start;

    assign is_last    = (r_idx == r_last);
    assign take       = r_valid && i_out_ready;
    assign o_can_load = !r_valid || (take && is_last);
    assign start      = i_load && (i_run.kind != fsce_pkg::SET_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (start) begin
            r_valid <= 1'b1;
        end else if (take && is_last) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_kind <= i_run.kind;
            r_lit  <= i_run.lit;
            r_idx  <= '0;
            r_last <= fsce_pkg::last_idx(i_run.kind);
        end else if (take && !is_last) begin
            r_idx <= r_idx + fsce_pkg::IdxW'(1);
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_char    = fsce_pkg::set_char(r_kind, r_idx, r_lit);
    assign o_last_of_run = is_last;

endmodule

// ===== rtl/core/format_spec_charset_expander_unit.sv =====
// format spec charset expander: first character of a byte is valid in the cycle after the accept
// throughput one input byte per cycle while each byte makes at most one character and the
// output is ready; a specifier run of n characters holds off the next byte until the emitter
// hands off the final character of the run
// synchronous active-low reset returns the parser to literal text and empties the emitter
// depends on fsce_pkg, fsce_parser, fsce_emitter
module format_spec_charset_expander_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input byte channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [fsce_pkg::CharW-1:0]    i_format_char,
    input  logic                          i_end_of_format,
    // output character channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [fsce_pkg::CharW-1:0]    o_out_char,
    output logic                          o_last_of_run
);

    fsce_pkg::t_run run;
    logic           can_load;
    logic           accept;

    // a byte is taken whenever the emitter is empty or hands off its final item now
    assign o_in_ready = can_load;
    assign accept     = i_in_valid && can_load;

    // phase tracking and set selection for the incoming byte
    fsce_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_format_char   (i_format_char),
        .i_end_of_format (i_end_of_format),
        .o_run           (run)
    );

    // bytes that produce nothing (percent opener, skipped fields, unknown specifier)
    // pass through without occupying the emitter
    fsce_emitter u_emitter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (accept),
        .i_run         (run),
        .o_can_load    (can_load),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_char    (o_out_char),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for format_spec_charset_expander_unit
// drives format bytes and checks every emitted character against an in-bench parser
// depends on fsce_pkg and the rtl of the unit
module tb_top;
    import fsce_pkg::*;

    localparam int MaxWait    = 18;
    localparam int StallLimit = 2000;
    localparam int TailCycles = 40;

    // one expected character on the output channel
    typedef struct packed {
        logic [CharW-1:0] ch;
        logic             last;
    } t_out_char;

    // one byte of stimulus with its end flag
    typedef struct packed {
        logic [CharW-1:0] ch;
        logic             eof;
    } t_fmt_byte;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [CharW-1:0] i_format_char;
    logic             i_end_of_format;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [CharW-1:0] o_out_char;
    logic             o_last_of_run;

    t_out_char   pending_chars[$];   // characters still owed by the unit, oldest first
    t_fmt_byte   format_bytes[$];    // bytes queued up for the sender
    t_phase      parse_phase_q;      // in-bench copy of the parse phase
    int unsigned errors = 0;
    int unsigned bytes_accepted = 0;
    int unsigned chars_checked = 0;
    int unsigned sets_emitted = 0;
    int unsigned idle_cycles = 0;
    bit          no_idle = 1'b0;

    format_spec_charset_expander_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_format_char   (i_format_char),
        .i_end_of_format (i_end_of_format),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_char      (o_out_char),
        .o_last_of_run   (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // parser copy: follows the byte stream and queues the characters owed
    // ------------------------------------------------------------------

    function automatic bit is_digit(input logic [CharW-1:0] c);
        return (c >= CharW'("0")) && (c <= CharW'("9"));
    endfunction

    // append one owed character at the young end of the queue
    function automatic void owe_char(input t_out_char x);
        pending_chars.insert(pending_chars.size(), x);
    endfunction

    function automatic void push_set(input string s);
        for (int i = 0; i < s.len(); i++) begin
            owe_char(t_out_char'{ch: CharW'(s[i]), last: 1'b0});
        end
    endfunction

    // the specifier byte closes the conversion, known ones emit their set
    function automatic void close_conversion(input logic [CharW-1:0] c);
        int unsigned before_n;
        before_n = pending_chars.size();
        case (c)
            "d", "i": push_set("0123456789-");
            "u":      push_set("0123456789");
            "x":      push_set("0123456789abcdef");
            "X", "p": push_set("0123456789ABCDEF");
            "o":      push_set("01234567");
            "b":      push_set("01");
            "f", "F": push_set("0123456789.-");
            "%":      push_set("%");
            default:  ;
        endcase
        if (pending_chars.size() != before_n) begin
            sets_emitted++;
        end
        parse_phase_q = PH_LIT;
    endfunction

    // length modifier slot, falls through to the specifier
    function automatic void take_length(input logic [CharW-1:0] c);
        if (c == CharW'("l")) begin
            parse_phase_q = PH_AFTER_L;
        end else if (c == CharW'("h")) begin
            parse_phase_q = PH_AFTER_H;
        end else if (c == CharW'("j") || c == CharW'("z")) begin
            parse_phase_q = PH_SPEC;
        end else begin
            close_conversion(c);
        end
    endfunction

    // optional precision dot, falls through to the length
    function automatic void take_precision(input logic [CharW-1:0] c);
        if (c == CharW'(".")) begin
            parse_phase_q = PH_PSTART;
        end else begin
            take_length(c);
        end
    endfunction

    function automatic void predict_byte(input logic [CharW-1:0] c, input logic eof);
        int unsigned first_n;
        t_out_char   tail;
        first_n = pending_chars.size();
        if (c == '0) begin
            // zero byte ends the string whatever the phase and is never echoed
            parse_phase_q = PH_LIT;
        end else begin
            case (parse_phase_q)
                PH_LIT: begin
                    if (c == CharW'("%")) begin
                        parse_phase_q = PH_FLAGS;
                    end else begin
                        owe_char(t_out_char'{ch: c, last: 1'b0});
                    end
                end
                PH_FLAGS: begin
                    // flags first, so a leading zero is a flag and not a width digit
                    if (c == CharW'("0") || c == CharW'("-") || c == CharW'("+") ||
                        c == CharW'(" ") || c == CharW'("#")) begin
                        parse_phase_q = PH_FLAGS;
                    end else if (is_digit(c)) begin
                        parse_phase_q = PH_WDIG;
                    end else if (c == CharW'("*")) begin
                        parse_phase_q = PH_PRECOPT;
                    end else begin
                        take_precision(c);
                    end
                end
                PH_WDIG: begin
                    if (is_digit(c)) begin
                        parse_phase_q = PH_WDIG;
                    end else begin
                        take_precision(c);
                    end
                end
                PH_PRECOPT: take_precision(c);
                PH_PSTART: begin
                    if (is_digit(c)) begin
                        parse_phase_q = PH_PDIG;
                    end else if (c == CharW'("*")) begin
                        parse_phase_q = PH_LENOPT;
                    end else begin
                        take_length(c);
                    end
                end
                PH_PDIG: begin
                    if (is_digit(c)) begin
                        parse_phase_q = PH_PDIG;
                    end else begin
                        take_length(c);
                    end
                end
                PH_LENOPT: take_length(c);
                PH_AFTER_L: begin
                    if (c == CharW'("l")) begin
                        parse_phase_q = PH_SPEC;
                    end else begin
                        close_conversion(c);
                    end
                end
                PH_AFTER_H: begin
                    if (c == CharW'("h")) begin
                        parse_phase_q = PH_SPEC;
                    end else begin
                        close_conversion(c);
                    end
                end
                PH_SPEC: close_conversion(c);
                default: parse_phase_q = PH_LIT;
            endcase
            // end flag drops any unfinished conversion after the byte is handled
            if (eof) begin
                parse_phase_q = PH_LIT;
            end
        end
        // mark the final character caused by this byte
        if (pending_chars.size() > first_n) begin
            tail = pending_chars.pop_back();
            tail.last = 1'b1;
            owe_char(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // monitor: checks output items first, then predicts from input items
    // both handshakes are sampled with their pre-edge values
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_out_char want;
        if (!i_rst_n) begin
            parse_phase_q = PH_LIT;
        end else begin
            if (o_out_valid && i_out_ready) begin
                chars_checked++;
                if (pending_chars.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected char: expected none, actual char %h last %b",
                             $time, o_out_char, o_last_of_run);
                end else begin
                    want = pending_chars.pop_front();
                    if (o_out_char !== want.ch) begin
                        errors++;
                        $display("%0t: out_char mismatch: expected %h, actual %h",
                                 $time, want.ch, o_out_char);
                    end
                    if (o_last_of_run !== want.last) begin
                        errors++;
                        $display("%0t: last_of_run mismatch: expected %b, actual %b",
                                 $time, want.last, o_last_of_run);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                bytes_accepted++;
                predict_byte(i_format_char, i_end_of_format);
            end
        end
    end

    // watchdog: a long stretch with no item moving on either side means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= StallLimit) begin
            $display("%0t: watchdog: no item moved for %0d cycles, %0d chars still expected",
                     $time, idle_cycles, pending_chars.size());
            $display("** format_spec_charset_expander_unit: FAILED **");
            $finish;
        end
    end

    // wait drawn per item: half back to back, half random up to MaxWait, none during a burst
    function automatic int unsigned draw_wait();
        if (no_idle || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(0, MaxWait);
    endfunction

    // receiver: ready may drop for a random stall after each accepted char
    initial begin : receiver
        int unsigned stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1));
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // one item: optional gap with valid low, then hold until accepted
    task automatic send_byte(input logic [CharW-1:0] c, input logic eof);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_format_char   <= c;
        i_end_of_format <= eof;
        do @(posedge i_clk); while (!(o_in_ready === 1'b1));
    endtask

    task automatic send_queued();
        t_fmt_byte b;
        while (format_bytes.size() != 0) begin
            b = format_bytes.pop_front();
            send_byte(b.ch, b.eof);
        end
    endtask

    function automatic void queue_byte(input logic [CharW-1:0] c, input logic eof);
        format_bytes.insert(format_bytes.size(), t_fmt_byte'{ch: c, eof: eof});
    endfunction

    function automatic void queue_text(input string s, input bit eof_on_last);
        for (int i = 0; i < s.len(); i++) begin
            queue_byte(CharW'(s[i]), eof_on_last && (i == s.len() - 1));
        end
    endfunction

    function automatic logic [CharW-1:0] rand_digit();
        return CharW'("0") + CharW'($urandom_range(0, 9));
    endfunction

    // nonzero byte that stays literal text
    function automatic logic [CharW-1:0] rand_literal();
        logic [CharW-1:0] c;
        c = CharW'($urandom_range(1, 255));
        if (c == CharW'("%")) begin
            c = c + CharW'(1);
        end
        return c;
    endfunction

    // a full conversion: percent, flags, width, precision, length, specifier
    function automatic void queue_conversion(input logic [CharW-1:0] spec);
        string flag_chars;
        int unsigned n;
        flag_chars = "0-+ #";
        queue_byte(CharW'("%"), 1'b0);
        n = $urandom_range(0, 3);
        repeat (n) queue_byte(CharW'(flag_chars[$urandom_range(0, 4)]), 1'b0);
        case ($urandom_range(0, 2))
            1: begin
                queue_byte(CharW'("1") + CharW'($urandom_range(0, 8)), 1'b0);
                if ($urandom_range(0, 1) == 1) queue_byte(rand_digit(), 1'b0);
            end
            2: queue_byte(CharW'("*"), 1'b0);
            default: ;
        endcase
        case ($urandom_range(0, 3))
            1: begin
                queue_byte(CharW'("."), 1'b0);
                queue_byte(rand_digit(), 1'b0);
                if ($urandom_range(0, 1) == 1) queue_byte(rand_digit(), 1'b0);
            end
            2: begin
                queue_byte(CharW'("."), 1'b0);
                queue_byte(CharW'("*"), 1'b0);
            end
            3: queue_byte(CharW'("."), 1'b0);
            default: ;
        endcase
        case ($urandom_range(0, 6))
            1: queue_text("l", 1'b0);
            2: queue_text("ll", 1'b0);
            3: queue_text("h", 1'b0);
            4: queue_text("hh", 1'b0);
            5: queue_text("j", 1'b0);
            6: queue_text("z", 1'b0);
            default: ;
        endcase
        queue_byte(spec, 1'b0);
    endfunction

    // a mostly well-formed format string: literal runs and conversions, then a terminator
    function automatic void queue_format_string();
        string spec_chars;
        int unsigned pieces;
        int unsigned pick;
        t_fmt_byte   b;
        spec_chars = "diuxXpobfF%";
        pieces = $urandom_range(1, 4);
        repeat (pieces) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                repeat ($urandom_range(1, 4)) queue_byte(rand_literal(), 1'b0);
            end else if (pick < 9) begin
                queue_conversion(CharW'(spec_chars[$urandom_range(0, spec_chars.len() - 1)]));
            end else begin
                // unknown or odd specifier byte
                queue_conversion(CharW'($urandom_range(1, 255)));
            end
        end
        // end either by flag on the last byte or by a zero byte
        if ($urandom_range(0, 9) < 7) begin
            b = format_bytes.pop_back();
            queue_byte(b.ch, 1'b1);
        end else begin
            queue_byte('0, 1'($urandom_range(0, 1)));
        end
    endfunction

    // pause the sender until every owed char has come out
    // the monitor first gets to predict any byte taken at the last edge
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extremes of the byte, the hh, j and l modifiers and the special cases
    task automatic test_directed();
        queue_byte(8'h01, 1'b0);
        queue_byte(8'hFF, 1'b1);          // literal with end flag
        queue_text("%%", 1'b0);           // percent specifier
        queue_text("%+08.3hhu", 1'b0);    // flags, width digits, precision digits, hh
        queue_text("%*.*jX", 1'b0);       // star width and precision, j length
        queue_text("%5", 1'b0);
        queue_byte('0, 1'b0);             // zero byte inside a conversion
        queue_text("%q", 1'b0);           // unknown specifier
        queue_text("%l", 1'b1);           // end flag drops an open conversion
        queue_text("%p", 1'b1);           // end flag on the closing specifier
        send_queued();
    endtask

    task automatic test_random_formats(input int unsigned n_bytes);
        int unsigned start;
        start = bytes_accepted;
        while (bytes_accepted - start < n_bytes) begin
            queue_format_string();
            send_queued();
        end
    endtask

    // no gaps on either side so specifier runs hold off input back to back
    task automatic test_back_to_back(input int unsigned n_bytes);
        int unsigned start;
        start = bytes_accepted;
        no_idle = 1'b1;
        while (bytes_accepted - start < n_bytes) begin
            queue_format_string();
            send_queued();
        end
        no_idle = 1'b0;
    endtask

    // cut-off conversions and raw noise, zero bytes and end flags anywhere
    task automatic test_broken_conversions(input int unsigned n_bytes);
        int unsigned start;
        int unsigned keep;
        t_fmt_byte   b;
        start = bytes_accepted;
        while (bytes_accepted - start < n_bytes) begin
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    queue_byte(CharW'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
            end else begin
                queue_conversion(CharW'("d"));
                keep = $urandom_range(1, format_bytes.size() - 1);
                while (format_bytes.size() > keep) void'(format_bytes.pop_back());
                if ($urandom_range(0, 1) == 0) begin
                    b = format_bytes.pop_back();
                    queue_byte(b.ch, 1'b1);
                end else begin
                    queue_byte('0, 1'b0);
                end
                // a literal right after shows whether the parser really went back
                queue_byte(rand_literal(), 1'b0);
            end
            send_queued();
        end
    endtask

    initial begin : run
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_format_char   <= '0;
        i_end_of_format <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_formats(230);
        wait_for_drain();
        test_back_to_back(80);
        test_broken_conversions(70);

        wait_for_drain();
        repeat (TailCycles) @(posedge i_clk);

        $display("run covered %0d format bytes and %0d checked chars", bytes_accepted,
                 chars_checked);
        $display("%0d conversions emitted a char set, %0d mismatches", sets_emitted, errors);
        if (errors == 0) begin
            $display("** format_spec_charset_expander_unit: PASSED **");
        end else begin
            $display("** format_spec_charset_expander_unit: FAILED **");
        end
        $finish;
    end

endmodule
